/* hdl/trade_or_book_vwap_price_defines.svh */
// Assertion macros used by the checker file of the fair-price block.
// No dependencies.
`ifndef TRADE_OR_BOOK_VWAP_PRICE_DEFINES_SVH
`define TRADE_OR_BOOK_VWAP_PRICE_DEFINES_SVH

// Concurrent check, disabled while reset is low.
`define TROBV_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("trobv assertion failed");

// Concurrent check that also runs through reset.
`define TROBV_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("trobv assertion failed");

`endif

/* hdl/trobv_pkg.sv */
// Types and constants of the trade/book fair-price block.
// No dependencies.
package trobv_pkg;
    localparam int MAX_LEVELS_DEF = 16;
    localparam int PRICE_W = 32;
    localparam int SIZE_W  = 24;
    localparam int TIME_W  = 37;
    localparam int LVLU_W  = 5;
    localparam int ENTRY_W = PRICE_W + SIZE_W;
    localparam int VAL_W   = 64;
    localparam int TOT_W   = 32;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_TRADE  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_UNCHANGED = 2'd0,
        ST_WEIGHTED  = 2'd1,
        ST_FALLBACK  = 2'd2,
        ST_ZERO      = 2'd3
    } t_status;

    typedef enum logic {
        CFG_LEVELS = 1'b0,
        CFG_CUTOFF = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_ISSUE, S_MULB, S_MULA, S_ACCA, S_FBWR,
        S_DIVB, S_DIVA, S_MUL1, S_MUL2, S_MUL3, S_DIVF, S_DONE
    } t_state;
endpackage

/* hdl/trobv_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module trobv_ram #(
    parameter int W = 8,
    parameter int D = 16,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* hdl/trobv_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on trobv_pkg. The quotient must fit in 32 bits.
module trobv_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [trobv_pkg::VAL_W-1:0]  i_dividend,
    input  logic [trobv_pkg::TOT_W-1:0]  i_divisor,
    output logic                         o_done,
    output logic [trobv_pkg::PRICE_W-1:0] o_quotient
);
    import trobv_pkg::*;

    logic [TOT_W-1:0]   r_rem, r_div;
    logic [PRICE_W-1:0] r_q;
    logic [5:0]         r_cnt;
    logic               r_busy, r_done;
    logic [TOT_W:0]     trial;
    logic               ge;

    assign trial = {r_rem, r_q[PRICE_W-1]};
    assign ge    = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= i_dividend[VAL_W-1:PRICE_W];
                r_q    <= i_dividend[PRICE_W-1:0];
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= ge ? TOT_W'(trial - {1'b0, r_div}) : trial[TOT_W-1:0];
                r_q   <= {r_q[PRICE_W-2:0], ge};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;
endmodule

/* hdl/trade_or_book_vwap_price.sv */
// Top level of the trade/book fair-price block: sequencer, book memories, divider.
// Depends on trobv_pkg, trobv_ram and trobv_div.
//
// Usage: input beats (i_valid/o_ready) carry a command: write one book level,
// market update, trade print or no-op. Each input beat yields exactly one output
// beat (o_valid/i_ready) with the fair bid, fair ask and a status code.
// Config writes (i_cfg_valid/o_cfg_ready) set levels_used (index 0) and the
// trade cutoff (index 1); they are taken at any time but belong in idle gaps.
// Level write, trade print and a market update inside the cutoff go from the
// check step straight to the output step. A recomputing update walks the book
// with one memory read per level, each level passing the issue, bid-multiply,
// ask-multiply and accumulate steps on the shared multiplier, then runs three
// divisions on one shared divider, or none if a side's total size is zero.
// A fallback ends after the first missing level.
// One item is in work at a time; a finished result sits in the output
// register while the next item is accepted and processed, and the sequencer
// holds its last step until the receiver takes the previous beat.
// Reset clears fair prices, trade time, present bits and the cutoff and sets
// levels_used to 1. Level memories are not cleared; only present levels are used.
module trade_or_book_vwap_price #(
    parameter int MAX_LEVELS = trobv_pkg::MAX_LEVELS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_cmd,
    input  logic [trobv_pkg::TIME_W-1:0]  i_time_usecs,
    input  logic                          i_side,
    input  logic [3:0]                    i_level,
    input  logic [trobv_pkg::PRICE_W-1:0] i_price,
    input  logic [trobv_pkg::SIZE_W-1:0]  i_size,
    input  logic                          i_present,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [trobv_pkg::PRICE_W-1:0] o_bid_price,
    output logic [trobv_pkg::PRICE_W-1:0] o_ask_price,
    output logic [1:0]                    o_status,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [trobv_pkg::TIME_W-1:0]  i_cfg_data
);
    import trobv_pkg::*;

    localparam int AW    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int CNT_W = $clog2(MAX_LEVELS + 1);

    t_state r_state, n_state;

    logic [LVLU_W-1:0]  r_levels;
    logic [TIME_W-1:0]  r_cutoff, r_last_time;
    logic [PRICE_W-1:0] r_fair_bid, r_fair_ask;
    logic [1:0]         r_present [MAX_LEVELS];

    t_cmd               r_cmd;
    logic [TIME_W-1:0]  r_time;
    logic               r_side, r_pres;
    logic [3:0]         r_level;
    logic [PRICE_W-1:0] r_price;
    logic [SIZE_W-1:0]  r_size;

    logic [CNT_W-1:0]   r_idx;
    logic [VAL_W-1:0]   r_bid_val, r_ask_val, r_prod, r_num;
    logic [TOT_W-1:0]   r_bid_tot, r_ask_tot;
    logic [SIZE_W-1:0]  r_bsz, r_asz;
    logic [PRICE_W-1:0] r_apr, r_avg_bid, r_avg_ask;
    t_status            r_status;

    logic               r_out_valid;
    logic [PRICE_W-1:0] r_out_bid, r_out_ask;
    t_status            r_out_status;

    // memory and shared-unit controls
    logic               we_bid, we_ask, mem_re;
    logic [AW-1:0]      mem_raddr, mem_waddr;
    logic [ENTRY_W-1:0] bid_rdata, ask_rdata;
    logic [PRICE_W-1:0] mul_a, mul_b;
    logic               div_start, div_done;
    logic [VAL_W-1:0]   div_dividend;
    logic [TOT_W-1:0]   div_divisor;
    logic [PRICE_W-1:0] div_q;

    logic               idx_done, idx_missing, tot_zero, over_cutoff, lvl_ok, out_free;
    logic [TIME_W:0]    diff;

    assign diff        = {1'b0, r_time} - {1'b0, r_last_time};
    assign over_cutoff = !diff[TIME_W] && (diff[TIME_W-1:0] > r_cutoff);
    assign idx_done    = 8'(r_idx) >= 8'(r_levels);
    assign idx_missing = (8'(r_idx) >= 8'(MAX_LEVELS)) || (r_present[r_idx[AW-1:0]] != 2'b11);
    assign tot_zero    = (r_bid_tot == '0) || (r_ask_tot == '0);
    assign lvl_ok      = 8'(r_level) < 8'(MAX_LEVELS);
    assign out_free    = !r_out_valid || i_ready;
    assign mem_waddr   = AW'(r_level);

    trobv_ram #(.W(ENTRY_W), .D(MAX_LEVELS)) u_bid_ram (
        .i_clk(i_clk), .i_we(we_bid), .i_waddr(mem_waddr), .i_wdata({r_price, r_size}),
        .i_re(mem_re), .i_raddr(mem_raddr), .o_rdata(bid_rdata)
    );

    trobv_ram #(.W(ENTRY_W), .D(MAX_LEVELS)) u_ask_ram (
        .i_clk(i_clk), .i_we(we_ask), .i_waddr(mem_waddr), .i_wdata({r_price, r_size}),
        .i_re(mem_re), .i_raddr(mem_raddr), .o_rdata(ask_rdata)
    );

    trobv_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start), .i_dividend(div_dividend),
        .i_divisor(div_divisor), .o_done(div_done), .o_quotient(div_q)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_valid) n_state = S_CHECK;
            S_CHECK: begin
                if (r_cmd == CMD_UPDATE && over_cutoff) n_state = S_ISSUE;
                else n_state = S_DONE;
            end
            S_ISSUE: begin
                if (idx_done) n_state = tot_zero ? S_DONE : S_DIVB;
                else if (idx_missing) n_state = S_FBWR;
                else n_state = S_MULB;
            end
            S_MULB:  n_state = S_MULA;
            S_MULA:  n_state = S_ACCA;
            S_ACCA:  n_state = S_ISSUE;
            S_FBWR:  n_state = S_DONE;
            S_DIVB:  if (div_done) n_state = S_DIVA;
            S_DIVA:  if (div_done) n_state = S_MUL1;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_MUL3;
            S_MUL3:  n_state = S_DIVF;
            S_DIVF:  if (div_done) n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_ready      = 1'b0;
        we_bid       = 1'b0;
        we_ask       = 1'b0;
        mem_re       = 1'b0;
        mem_raddr    = r_idx[AW-1:0];
        mul_a        = r_apr;
        mul_b        = PRICE_W'(r_asz);
        div_start    = 1'b0;
        div_dividend = r_bid_val;
        div_divisor  = r_bid_tot;
        unique case (r_state)
            S_IDLE:  o_ready = 1'b1;
            S_CHECK: begin
                we_bid = (r_cmd == CMD_WRITE) && lvl_ok && !r_side;
                we_ask = (r_cmd == CMD_WRITE) && lvl_ok && r_side;
            end
            S_ISSUE: begin
                mem_re = !idx_done;
                if (idx_missing) mem_raddr = '0;
                div_start = idx_done && !tot_zero;
            end
            S_MULB: begin
                mul_a = bid_rdata[ENTRY_W-1:SIZE_W];
                mul_b = PRICE_W'(bid_rdata[SIZE_W-1:0]);
            end
            S_DIVB: begin
                div_start    = div_done;
                div_dividend = r_ask_val;
                div_divisor  = r_ask_tot;
            end
            S_MUL1: begin
                mul_a = r_avg_bid;
                mul_b = r_ask_tot;
            end
            S_MUL2: begin
                mul_a = r_avg_ask;
                mul_b = r_bid_tot;
            end
            S_MUL3: begin
                div_start    = 1'b1;
                div_dividend = r_num + r_prod;
                div_divisor  = r_bid_tot + r_ask_tot;
            end
            default: ;
        endcase
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_levels    <= LVLU_W'(1);
            r_cutoff    <= '0;
            r_last_time <= '0;
            r_fair_bid  <= '0;
            r_fair_ask  <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < MAX_LEVELS; k++) r_present[k] <= 2'b00;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_LEVELS: r_levels <= i_cfg_data[LVLU_W-1:0];
                    CFG_CUTOFF: r_cutoff <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_DONE && out_free) r_out_valid <= 1'b1;
            else if (r_out_valid && i_ready) r_out_valid <= 1'b0;
            case (r_state)
                S_CHECK: begin
                    if (r_cmd == CMD_WRITE && lvl_ok) begin
                        if (r_side) r_present[mem_waddr][1] <= r_pres;
                        else r_present[mem_waddr][0] <= r_pres;
                    end
                    if (r_cmd == CMD_TRADE) begin
                        r_fair_bid  <= r_price;
                        r_fair_ask  <= r_price;
                        r_last_time <= r_time;
                    end
                end
                S_FBWR: begin
                    if (r_present[0][0]) r_fair_bid <= bid_rdata[ENTRY_W-1:SIZE_W];
                    if (r_present[0][1]) r_fair_ask <= ask_rdata[ENTRY_W-1:SIZE_W];
                end
                S_DIVF: begin
                    if (div_done) begin
                        r_fair_bid <= div_q;
                        r_fair_ask <= div_q;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_cmd   <= t_cmd'(i_cmd);
                    r_time  <= i_time_usecs;
                    r_side  <= i_side;
                    r_level <= i_level;
                    r_price <= i_price;
                    r_size  <= i_size;
                    r_pres  <= i_present;
                end
            end
            S_CHECK: begin
                r_idx     <= '0;
                r_bid_val <= '0;
                r_ask_val <= '0;
                r_bid_tot <= '0;
                r_ask_tot <= '0;
                r_status  <= ST_UNCHANGED;
            end
            S_ISSUE: begin
                if (idx_done && tot_zero) r_status <= ST_ZERO;
            end
            S_MULB: begin
                r_prod <= mul_a * mul_b;
                r_bsz  <= bid_rdata[SIZE_W-1:0];
                r_asz  <= ask_rdata[SIZE_W-1:0];
                r_apr  <= ask_rdata[ENTRY_W-1:SIZE_W];
            end
            S_MULA: begin
                r_bid_val <= r_bid_val + r_prod;
                r_bid_tot <= r_bid_tot + TOT_W'(r_bsz);
                r_prod    <= mul_a * mul_b;
            end
            S_ACCA: begin
                r_ask_val <= r_ask_val + r_prod;
                r_ask_tot <= r_ask_tot + TOT_W'(r_asz);
                r_idx     <= r_idx + CNT_W'(1);
            end
            S_FBWR: r_status <= ST_FALLBACK;
            S_DIVB: if (div_done) r_avg_bid <= div_q;
            S_DIVA: if (div_done) r_avg_ask <= div_q;
            S_MUL1: r_prod <= mul_a * mul_b;
            S_MUL2: begin
                r_num  <= r_prod;
                r_prod <= mul_a * mul_b;
            end
            S_DIVF: if (div_done) r_status <= ST_WEIGHTED;
            S_DONE: begin
                if (out_free) begin
                    r_out_bid    <= r_fair_bid;
                    r_out_ask    <= r_fair_ask;
                    r_out_status <= r_status;
                end
            end
            default: ;
        endcase
    end

    assign o_valid     = r_out_valid;
    assign o_bid_price = r_out_bid;
    assign o_ask_price = r_out_ask;
    assign o_status    = r_out_status;
endmodule

/* hdl/trobv_checker.sv */
// Port-level checks for the fair-price block, bound to its top level.
// Depends on trobv_pkg and trade_or_book_vwap_price_defines.svh.
`include "trade_or_book_vwap_price_defines.svh"

module trobv_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [trobv_pkg::PRICE_W-1:0] o_bid_price,
    input logic [trobv_pkg::PRICE_W-1:0] o_ask_price,
    input logic [1:0]                    o_status
);
    import trobv_pkg::*;

    // hold a result until taken
    `TROBV_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid)
    // one item in work at a time
    `TROBV_ASSERT(a_one_item, i_clk, i_rst_n, i_valid && o_ready |=> !o_ready)
    // reset empties the output and opens the input
    `TROBV_ASSERT_NR(a_reset, i_clk, !i_rst_n |=> !o_valid && o_ready)
    // a weighted result sets both sides alike
    `TROBV_ASSERT(a_weighted_eq, i_clk, i_rst_n,
        o_valid && (o_status == ST_WEIGHTED) |-> o_bid_price == o_ask_price)
endmodule

bind trade_or_book_vwap_price trobv_checker u_trobv_checker (.*);
